// ===== sv/perlin_noise_3d_sampler_macros.svh =====
// assertion macros shared by the noise sampler rtl
// expects clk and rst in the scope where a macro is used
`ifndef PERLIN_NOISE_3D_SAMPLER_MACROS_SVH
`define PERLIN_NOISE_3D_SAMPLER_MACROS_SVH

`define PNS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define PNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pns_pkg.sv =====
// shared constants, codes and gradient table for the noise sampler
// no dependencies
`default_nettype none

package pns_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int TABLE_DEPTH_DEF = 256;

  localparam int COORD_W  = 48;
  localparam int ORIGIN_W = 24;
  localparam int STEP_W   = 32;
  localparam int LIMIT_W  = 32;
  localparam int TVAL_W   = 8;
  localparam int OUT_W    = 20;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_BITS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 2'd2;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic signed [1:0] GP = 2'sb01;
  localparam logic signed [1:0] GN = 2'sb11;
  localparam logic signed [1:0] GZ = 2'sb00;

  localparam logic signed [1:0] GRAD_X [16] = '{
    GP, GN, GP, GN, GP, GN, GP, GN, GZ, GZ, GZ, GZ, GP, GZ, GN, GZ};
  localparam logic signed [1:0] GRAD_Y [16] = '{
    GP, GP, GN, GN, GZ, GZ, GZ, GZ, GP, GN, GP, GN, GP, GN, GP, GN};
  localparam logic signed [1:0] GRAD_Z [16] = '{
    GZ, GZ, GZ, GZ, GP, GP, GN, GN, GP, GP, GN, GN, GZ, GP, GZ, GN};

endpackage

`default_nettype wire

// ===== sv/pns_ram.sv =====
// one copy of the permutation table, one write port and two registered reads
// no dependencies
`default_nettype none

module pns_ram #(
  parameter int DEPTH = 256,
  parameter int DW    = 8
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output      logic [DW-1:0]            rdata0,
  output      logic [DW-1:0]            rdata1
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pns_divrem.sv =====
// pipelined restoring remainder unit, pns_pkg::DIV_BITS (4) quotient bits per stage
// depends on pns_pkg
`default_nettype none

module pns_divrem #(
  parameter int W = 16
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [W-1:0]               dividend,
  input  wire logic [pns_pkg::STEP_W-1:0] divisor,
  output      logic [W-1:0]               rem
);

  localparam int G  = pns_pkg::DIV_BITS;
  localparam int NS = (W + G - 1) / G;
  localparam int QW = NS * G;
  localparam int SW = pns_pkg::STEP_W;
  localparam int CW = (W + 1 > SW) ? W + 1 : SW;

  logic [W-1:0]  r_q [NS];
  logic [QW-1:0] q_q [NS];
  logic [SW-1:0] s_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [W-1:0]  r_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] s_in;
    logic [W-1:0]  r_nx;
    logic [QW-1:0] q_nx;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign q_in = QW'(dividend);
      assign s_in = divisor;
    end else begin : g_rest
      assign r_in = r_q[s-1];
      assign q_in = q_q[s-1];
      assign s_in = s_q[s-1];
    end

    always_comb begin
      logic [CW-1:0] t;
      r_nx = r_in;
      q_nx = q_in;
      for (int j = 0; j < G; j++) begin
        t = CW'({r_nx, q_nx[QW-1]});
        q_nx = q_nx << 1;
        if (t >= CW'(s_in)) begin
          t = t - CW'(s_in);
        end
        r_nx = t[W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[s] <= r_nx;
        q_q[s] <= q_nx;
        s_q[s] <= s_in;
      end
    end
  end

  assign rem = r_q[NS-1];

endmodule

`default_nettype wire

// ===== sv/pns_fade.sv =====
// quintic fade curve over three multiplier stages
// no dependencies
`default_nettype none

module pns_fade #(
  parameter int F = 16
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [F-1:0]        t,
  output      logic signed [F+1:0] f
);

  localparam int PW = F + 5;
  localparam logic signed [PW-1:0] FIFTEEN_ONE = PW'(15 * (1 << F));
  localparam logic signed [PW-1:0] TEN_ONE     = PW'(10 * (1 << F));

  logic signed [PW-1:0] u;
  logic signed [F+PW:0] tu;
  logic [2*F-1:0]       tt;
  logic [2*F-1:0]       ttt;
  logic signed [F+PW:0] tp;

  logic [F-1:0]         t_a;
  logic [F-1:0]         t2_a;
  logic signed [PW-1:0] p_a;
  logic [F-1:0]         t3_b;
  logic signed [PW-1:0] p_b;

  assign u   = $signed(PW'(t) * PW'(6)) - FIFTEEN_ONE;
  assign tu  = $signed({1'b0, t}) * u;
  assign tt  = (2*F)'(t) * (2*F)'(t);
  assign ttt = (2*F)'(t2_a) * (2*F)'(t_a);
  assign tp  = $signed({1'b0, t3_b}) * p_b;

  always_ff @(posedge clk) begin
    if (en) begin
      t_a  <= t;
      t2_a <= tt[2*F-1:F];
      p_a  <= PW'(tu >>> F) + TEN_ONE;
      t3_b <= ttt[2*F-1:F];
      p_b  <= p_a;
      f    <= (F+2)'(tp >>> F);
    end
  end

endmodule

`default_nettype wire

// ===== sv/pns_lerp.sv =====
// two-stage linear interpolation, a + floor(w * (b - a))
// no dependencies
`default_nettype none

module pns_lerp #(
  parameter int W  = 20,
  parameter int WW = 18,
  parameter int F  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [WW-1:0] w,
  input  wire logic signed [W-1:0]  a,
  input  wire logic signed [W-1:0]  b,
  output      logic signed [W-1:0]  y
);

  localparam int PW = WW + W + 1;

  logic signed [W:0]    diff;
  logic signed [PW-1:0] prod;
  logic signed [W-1:0]  a_q;

  assign diff = $signed({b[W-1], b}) - $signed({a[W-1], a});

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= w * diff;
      a_q  <= a;
      y    <= a_q + W'(prod >>> F);
    end
  end

endmodule

`default_nettype wire

// ===== sv/perlin_noise_3d_sampler.sv =====
// top level of the 3d noise sampler: input split, hashing, dot products, lerps
// depends on pns_pkg, pns_ram, pns_divrem, pns_fade, pns_lerp and the macro header
//
//  channel   direction  transfer when           carries
//  input     in         in_valid & !in_stall    kind, table fields, coords, y_step, y_limit
//  output    out        out_valid & !out_stall  noise_value (samples only)
//  config    in         cfg_write               cfg_index, cfg_data
//
// one item per cycle while the output is not stalled
// the pipeline depth follows the y remainder unit, 4 quotient bits per stage
// table loads write each table copy at the stage that reads it, so order is kept
// a stalled output freezes the whole pipeline; no bubbles are lost or repeated
// reset clears valid bits and origins; the table holds nothing until loaded
`default_nettype none

`include "perlin_noise_3d_sampler_macros.svh"

module perlin_noise_3d_sampler #(
  parameter int FRAC_BITS   = pns_pkg::FRAC_BITS_DEF,
  parameter int TABLE_DEPTH = pns_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic                                kind,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]      table_index,
  input  wire logic [pns_pkg::TVAL_W-1:0]          table_value,
  input  wire logic signed [pns_pkg::COORD_W-1:0]  coord_x,
  input  wire logic signed [pns_pkg::COORD_W-1:0]  coord_y,
  input  wire logic signed [pns_pkg::COORD_W-1:0]  coord_z,
  input  wire logic [pns_pkg::STEP_W-1:0]          y_step,
  input  wire logic signed [pns_pkg::LIMIT_W-1:0]  y_limit,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic signed [pns_pkg::OUT_W-1:0]    noise_value,
  input  wire logic                                cfg_write,
  input  wire logic [pns_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pns_pkg::CFG_W-1:0]           cfg_data
);

  localparam int F    = FRAC_BITS;
  localparam int CW   = $clog2(TABLE_DEPTH);
  localparam int DW   = F + CW;
  localparam int TW   = pns_pkg::TVAL_W;
  localparam int NS   = (F + pns_pkg::DIV_BITS - 1) / pns_pkg::DIV_BITS;
  localparam int S_C  = 4;
  localparam int S_L  = 3 + NS;
  localparam int S_N  = S_L + 1;
  localparam int S_X  = S_N + 2;
  localparam int S_Y  = S_X + 2;
  localparam int S_Z  = S_Y + 2;
  localparam int LAST = S_Z + 1;
  localparam int VW   = F + 4;
  localparam int WW   = F + 2;
  localparam int OW   = pns_pkg::OUT_W;
  localparam int SW   = (VW > OW + 1) ? VW : OW + 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (OW - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
  localparam logic signed [WW-1:0] FADE_ONE = WW'(1 << F);

  function automatic logic signed [VW-1:0] term(logic signed [1:0] g,
                                                logic signed [F:0] v);
    logic signed [VW-1:0] e;
    e = VW'(v);
    if (g == pns_pkg::GP) begin
      return e;
    end else if (g == pns_pkg::GN) begin
      return -e;
    end else begin
      return '0;
    end
  endfunction

  logic en;
  logic [LAST:1] vld;
  logic [LAST:1] kind_d;

  logic [pns_pkg::ORIGIN_W-1:0] origin_x, origin_y, origin_z;

  logic [DW-1:0] dx, dy, dz;
  logic [CW-1:0] cx1, cy1, cz1, cy2, cz2, cz3;
  logic [F-1:0]  fr1 [3];
  logic [F-1:0]  fr_d [2:S_L-1][3];
  logic [pns_pkg::STEP_W-1:0] step1, step2;
  logic signed [pns_pkg::LIMIT_W-1:0] lim1;
  logic [CW-1:0] tidx_d [1:3];
  logic [TW-1:0] tval_d [1:3];
  logic          clamp;
  logic [F-1:0]  m_d [2:S_L-1];
  logic          qon_d [2:S_L-1];
  logic [F-1:0]  rem;

  logic [TW-1:0] a2, b2;
  logic [TW-1:0] h3 [4];
  logic [TW-1:0] c4 [8];
  logic [3:0]    c_d [S_C+1:S_L][8];

  logic signed [WW-1:0] fo [3];
  logic signed [WW-1:0] f_d [S_C+1:S_Y][3];

  logic [F-1:0] lx, ly, lz;
  logic signed [VW-1:0] nv [8];
  logic signed [VW-1:0] xv [4];
  logic signed [VW-1:0] yv [2];
  logic signed [VW-1:0] rv;
  logic signed [SW-1:0] rs;

  logic smp_c, smp_r, fade_ok;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAST] && (kind_d[LAST] == pns_pkg::KIND_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pns_pkg::REG_ORIGIN_X: origin_x <= cfg_data;
        pns_pkg::REG_ORIGIN_Y: origin_y <= cfg_data;
        pns_pkg::REG_ORIGIN_Z: origin_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:1], in_valid};
    end
  end

  assign dx = DW'(coord_x) + DW'(origin_x);
  assign dy = DW'(coord_y) + DW'(origin_y);
  assign dz = DW'(coord_z) + DW'(origin_z);
  assign clamp = !lim1[pns_pkg::LIMIT_W-1]
               && (lim1[pns_pkg::LIMIT_W-2:0] < (pns_pkg::LIMIT_W-1)'(fr1[1]));

  always_ff @(posedge clk) begin
    if (en) begin
      kind_d    <= {kind_d[LAST-1:1], kind};
      cx1       <= dx[DW-1:F];
      cy1       <= dy[DW-1:F];
      cz1       <= dz[DW-1:F];
      fr1[0]    <= dx[F-1:0];
      fr1[1]    <= dy[F-1:0];
      fr1[2]    <= dz[F-1:0];
      step1     <= y_step;
      lim1      <= y_limit;
      tidx_d[1] <= table_index;
      tval_d[1] <= table_value;
      for (int k = 2; k <= 3; k++) begin
        tidx_d[k] <= tidx_d[k-1];
        tval_d[k] <= tval_d[k-1];
      end
      cy2 <= cy1;
      cz2 <= cz1;
      cz3 <= cz2;
      step2     <= step1;
      m_d[2]    <= clamp ? lim1[F-1:0] : fr1[1];
      qon_d[2]  <= step1 != '0;
      fr_d[2]   <= fr1;
      for (int k = 3; k <= S_L-1; k++) begin
        m_d[k]   <= m_d[k-1];
        qon_d[k] <= qon_d[k-1];
        fr_d[k]  <= fr_d[k-1];
      end
      c_d[S_C+1] <= '{c4[0][3:0], c4[1][3:0], c4[2][3:0], c4[3][3:0],
                      c4[4][3:0], c4[5][3:0], c4[6][3:0], c4[7][3:0]};
      for (int k = S_C+2; k <= S_L; k++) begin
        c_d[k] <= c_d[k-1];
      end
      f_d[S_C+1] <= fo;
      for (int k = S_C+2; k <= S_Y; k++) begin
        f_d[k] <= f_d[k-1];
      end
      lx <= fr_d[S_L-1][0];
      ly <= qon_d[S_L-1] ? fr_d[S_L-1][1] - m_d[S_L-1] + rem : fr_d[S_L-1][1];
      lz <= fr_d[S_L-1][2];
      for (int i = 0; i < 8; i++) begin
        nv[i] <= term(pns_pkg::GRAD_X[c_d[S_L][i]], $signed({i[0], lx}))
               + term(pns_pkg::GRAD_Y[c_d[S_L][i]], $signed({i[1], ly}))
               + term(pns_pkg::GRAD_Z[c_d[S_L][i]], $signed({i[2], lz}));
      end
      if (rs > SAT_HI) begin
        noise_value <= OW'(SAT_HI);
      end else if (rs < SAT_LO) begin
        noise_value <= OW'(SAT_LO);
      end else begin
        noise_value <= OW'(rs);
      end
    end
  end

  assign rs = SW'(rv);

  pns_ram #(.DEPTH(TABLE_DEPTH), .DW(TW)) u_ram_a (
    .clk    (clk),
    .en     (en),
    .we     (vld[1] && (kind_d[1] == pns_pkg::KIND_LOAD)),
    .waddr  (tidx_d[1]),
    .wdata  (tval_d[1]),
    .raddr0 (cx1),
    .raddr1 (cx1 + CW'(1)),
    .rdata0 (a2),
    .rdata1 (b2)
  );

  for (genvar j = 0; j < 2; j++) begin : g_ram_h
    pns_ram #(.DEPTH(TABLE_DEPTH), .DW(TW)) u_ram (
      .clk    (clk),
      .en     (en),
      .we     (vld[2] && (kind_d[2] == pns_pkg::KIND_LOAD)),
      .waddr  (tidx_d[2]),
      .wdata  (tval_d[2]),
      .raddr0 (CW'(a2) + cy2 + CW'(j)),
      .raddr1 (CW'(b2) + cy2 + CW'(j)),
      .rdata0 (h3[2*j]),
      .rdata1 (h3[2*j+1])
    );
  end

  for (genvar j = 0; j < 4; j++) begin : g_ram_c
    pns_ram #(.DEPTH(TABLE_DEPTH), .DW(TW)) u_ram (
      .clk    (clk),
      .en     (en),
      .we     (vld[3] && (kind_d[3] == pns_pkg::KIND_LOAD)),
      .waddr  (tidx_d[3]),
      .wdata  (tval_d[3]),
      .raddr0 (CW'(h3[j]) + cz3),
      .raddr1 (CW'(h3[j]) + cz3 + CW'(1)),
      .rdata0 (c4[j]),
      .rdata1 (c4[j+4])
    );
  end

  pns_divrem #(.W(F)) u_divrem (
    .clk      (clk),
    .en       (en),
    .dividend (m_d[2]),
    .divisor  (step2),
    .rem      (rem)
  );

  for (genvar j = 0; j < 3; j++) begin : g_fade
    pns_fade #(.F(F)) u_fade (
      .clk (clk),
      .en  (en),
      .t   (fr1[j]),
      .f   (fo[j])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_lerp_x
    pns_lerp #(.W(VW), .WW(WW), .F(F)) u_lerp (
      .clk (clk), .en (en), .w (f_d[S_N][0]), .a (nv[2*k]), .b (nv[2*k+1]), .y (xv[k])
    );
  end

  for (genvar k = 0; k < 2; k++) begin : g_lerp_y
    pns_lerp #(.W(VW), .WW(WW), .F(F)) u_lerp (
      .clk (clk), .en (en), .w (f_d[S_X][1]), .a (xv[2*k]), .b (xv[2*k+1]), .y (yv[k])
    );
  end

  pns_lerp #(.W(VW), .WW(WW), .F(F)) u_lerp_z (
    .clk (clk), .en (en), .w (f_d[S_Y][2]), .a (yv[0]), .b (yv[1]), .y (rv)
  );

  assign smp_c   = vld[S_C] && (kind_d[S_C] == pns_pkg::KIND_SAMPLE);
  assign smp_r   = vld[S_L-1] && (kind_d[S_L-1] == pns_pkg::KIND_SAMPLE) && qon_d[S_L-1];
  assign fade_ok = (fo[0] >= 0) && (fo[0] <= FADE_ONE) && (fo[1] >= 0) && (fo[1] <= FADE_ONE)
                && (fo[2] >= 0) && (fo[2] <= FADE_ONE);

  `PNS_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld[1], "transfer lost at entry")
  `PNS_ASSERT_NEXT(a_hold_on_stall, !en, $stable(vld), "pipeline moved while stalled")
  `PNS_ASSERT_IMPLIES(a_fade_range, smp_c, fade_ok, "fade out of range")
  `PNS_ASSERT_IMPLIES(a_rem_bound, smp_r, rem <= m_d[S_L-1], "remainder above dividend")

endmodule

`default_nettype wire

// ===== sim/perlin_noise_3d_sampler_tb.sv =====
// self-checking testbench for the 3d noise sampler: loads the permutation table,
// sends samples under random idling and back-pressure and checks every noise value
// depends on pns_pkg and the perlin_noise_3d_sampler rtl
`default_nettype none

module perlin_noise_3d_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FRAC      = pns_pkg::FRAC_BITS_DEF;
  localparam int  COORD_W   = pns_pkg::COORD_W;
  localparam int  STEP_W    = pns_pkg::STEP_W;
  localparam int  LIMIT_W   = pns_pkg::LIMIT_W;
  localparam int  OUT_W     = pns_pkg::OUT_W;
  localparam int  TVAL_W    = pns_pkg::TVAL_W;
  localparam int  CFG_W     = pns_pkg::CFG_W;
  localparam int  CFG_IDX_W = pns_pkg::CFG_IDX_W;
  localparam int  SETTLE  = 40;
  localparam int  LIMIT   = 600000;
  localparam longint ONE  = longint'(1) << FRAC;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = pns_pkg::KIND_LOAD;
  logic [7:0] table_index = '0;
  logic [TVAL_W-1:0] table_value = '0;
  logic signed [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [STEP_W-1:0] y_step = '0;
  logic signed [LIMIT_W-1:0] y_limit = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] noise_value;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = pns_pkg::REG_ORIGIN_X;
  logic [CFG_W-1:0] cfg_data = '0;

  perlin_noise_3d_sampler dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [7:0] perm_copy [256];
  longint org_x = 0, org_y = 0, org_z = 0;
  logic signed [OUT_W-1:0] noise_q [$];

  int cycles = 0, mismatches = 0, checked = 0, samples_sent = 0, loads_sent = 0;
  bit failed = 0;
  int hold_left = 0;
  bit hold_req = 0;
  int stall_level = 0;

  function automatic longint fshift(longint v);
    return v >>> FRAC;
  endfunction

  function automatic longint fade_of(longint t);
    longint p, t2, t3;
    p  = fshift(t * (6 * t - 15 * ONE)) + 10 * ONE;
    t2 = fshift(t * t);
    t3 = fshift(t2 * t);
    return fshift(t3 * p);
  endfunction

  function automatic longint blend(longint w, longint a, longint b);
    return a + fshift(w * (b - a));
  endfunction

  function automatic longint grad_dot(longint h, longint x, longint y, longint z);
    return longint'(pns_pkg::GRAD_X[h[3:0]]) * x + longint'(pns_pkg::GRAD_Y[h[3:0]]) * y
         + longint'(pns_pkg::GRAD_Z[h[3:0]]) * z;
  endfunction

  function automatic longint hash8(longint i);
    return longint'(perm_copy[i & 255]);
  endfunction

  function automatic logic signed [OUT_W-1:0] noise_of(
      logic signed [COORD_W-1:0] cx, cy, cz, logic [STEP_W-1:0] ys,
      logic signed [LIMIT_W-1:0] yl);
    longint dx, dy, dz, fx, fy, fz, ox, lim, m, q, ly, lx1, ly1, lz1;
    longint cxl, cyl, czl, a, b, h00, h10, h01, h11, r;
    longint n [8];
    longint c [8];
    dx = longint'(cx) + org_x;
    dy = longint'(cy) + org_y;
    dz = longint'(cz) + org_z;
    cxl = (dx >>> FRAC) & 255; cyl = (dy >>> FRAC) & 255; czl = (dz >>> FRAC) & 255;
    fx = dx & (ONE - 1); fy = dy & (ONE - 1); fz = dz & (ONE - 1);
    ox = 0;
    if (ys != 0) begin
      lim = longint'(yl);
      m = (lim >= 0 && lim < fy) ? lim : fy;
      q = longint'(ys);
      ox = (m / q) * q;
    end
    a = hash8(cxl); b = hash8(cxl + 1);
    h00 = hash8(a + cyl); h10 = hash8(b + cyl);
    h01 = hash8(a + cyl + 1); h11 = hash8(b + cyl + 1);
    c[0] = hash8(h00 + czl); c[1] = hash8(h10 + czl);
    c[2] = hash8(h01 + czl); c[3] = hash8(h11 + czl);
    c[4] = hash8(h00 + czl + 1); c[5] = hash8(h10 + czl + 1);
    c[6] = hash8(h01 + czl + 1); c[7] = hash8(h11 + czl + 1);
    ly = fy - ox; lx1 = fx - ONE; ly1 = ly - ONE; lz1 = fz - ONE;
    n[0] = grad_dot(c[0], fx, ly, fz);   n[1] = grad_dot(c[1], lx1, ly, fz);
    n[2] = grad_dot(c[2], fx, ly1, fz);  n[3] = grad_dot(c[3], lx1, ly1, fz);
    n[4] = grad_dot(c[4], fx, ly, lz1);  n[5] = grad_dot(c[5], lx1, ly, lz1);
    n[6] = grad_dot(c[6], fx, ly1, lz1); n[7] = grad_dot(c[7], lx1, ly1, lz1);
    fx = fade_of(fx); fy = fade_of(fy); fz = fade_of(fz);
    r = blend(fz, blend(fy, blend(fx, n[0], n[1]), blend(fx, n[2], n[3])),
              blend(fy, blend(fx, n[4], n[5]), blend(fx, n[6], n[7])));
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r[OUT_W-1:0];
  endfunction

  // one transfer on the input channel; call at a rising edge
  task automatic send_item(logic k, logic [7:0] ti, logic [7:0] tv,
      logic signed [COORD_W-1:0] cx, cy, cz, logic [STEP_W-1:0] ys,
      logic signed [LIMIT_W-1:0] yl);
    kind <= k; table_index <= ti; table_value <= tv;
    coord_x <= cx; coord_y <= cy; coord_z <= cz; y_step <= ys; y_limit <= yl;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == pns_pkg::KIND_LOAD) begin
      perm_copy[ti] = tv;
      loads_sent++;
    end else begin
      noise_q.push_back(noise_of(cx, cy, cz, ys, yl));
      samples_sent++;
    end
  endtask

  task automatic send_sample(logic signed [COORD_W-1:0] cx, cy, cz,
      logic [STEP_W-1:0] ys, logic signed [LIMIT_W-1:0] yl);
    send_item(pns_pkg::KIND_SAMPLE, 8'd0, 8'd0, cx, cy, cz, ys, yl);
  endtask

  task automatic pause_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      pns_pkg::REG_ORIGIN_X: org_x = longint'(v);
      pns_pkg::REG_ORIGIN_Y: org_y = longint'(v);
      default:               org_z = longint'(v);
    endcase
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0:       return COORD_W'({$urandom, $urandom});
      1:       return COORD_W'(longint'($urandom_range(2000000)) - 1000000);
      2:       return {{(COORD_W-24){1'($urandom_range(1))}}, 24'($urandom)};
      default: return COORD_W'(longint'($urandom) << 8);
    endcase
  endfunction

  task automatic send_random_sample();
    logic [STEP_W-1:0] ys;
    logic signed [LIMIT_W-1:0] yl;
    case ($urandom_range(4))
      0:       ys = '0;
      1:       ys = $urandom_range(1, 16);
      2:       ys = $urandom_range(1, 70000);
      3:       ys = $urandom;
      default: ys = $urandom_range(100, 9000);
    endcase
    case ($urandom_range(3))
      0:       yl = $urandom;
      1:       yl = $urandom_range(0, 70000);
      2:       yl = -$signed(32'($urandom_range(1, 1000)));
      default: yl = 32'h7fff_ffff;
    endcase
    send_sample(rand_coord(), rand_coord(), rand_coord(), ys, yl);
  endtask

  task automatic run_bursts(int total);
    int sent, len;
    sent = 0;
    while (sent < total) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (len) begin
        if ($urandom_range(9) == 0)
          send_item(pns_pkg::KIND_LOAD, 8'($urandom), 8'($urandom), '0, '0, '0, '0, '0);
        else
          send_random_sample();
        sent++;
      end
      if ($urandom_range(2) != 0) pause_input($urandom_range(1, 6));
    end
  endtask

  task automatic test_table_load();
    logic [7:0] order [256];
    logic [7:0] tmp;
    int j;
    for (int i = 0; i < 256; i++) order[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = int'($urandom_range(i));
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int i = 0; i < 256; i++) begin
      send_item(pns_pkg::KIND_LOAD, 8'(i), order[i], '0, '0, '0, '0, '0);
      if ($urandom_range(15) == 0) pause_input($urandom_range(1, 4));
    end
  endtask

  task automatic test_directed();
    logic signed [COORD_W-1:0] cmax, cmin;
    cmax = {1'b0, {(COORD_W-1){1'b1}}};
    cmin = {1'b1, {(COORD_W-1){1'b0}}};
    send_sample('0, '0, '0, '0, '0);
    send_sample(cmax, cmax, cmax, '0, -32'sd1);
    send_sample(cmin, cmin, cmin, '1, 32'sh7fff_ffff);
    send_sample(-48'sd1, -48'sd1, -48'sd1, 32'd1, -32'sd1);
    send_sample(48'hffff, 48'hffff, 48'hffff, 32'h100, 32'sh8000_0000);
    send_sample(48'h18000, 48'h1c000, 48'h8000, 32'h4000, 32'sd0);
    send_sample(48'h18000, 48'h1c000, 48'h8000, 32'h4000, 32'sh2000);
    send_sample(48'h18000, 48'h1c000, 48'h8000, 32'h4000, 32'sh20000);
    send_sample(48'h12345, 48'h0fff0, 48'hfedcba, 32'h3, 32'sh7);
    send_sample(48'h10000, 48'h20000, 48'h30000, '1, '0);
    send_item(pns_pkg::KIND_LOAD, 8'hff, 8'hff, '0, '0, '0, '0, '0);
    send_item(pns_pkg::KIND_LOAD, 8'h00, 8'h00, '0, '0, '0, '0, '0);
    send_sample(48'hff8000, 48'h7fff, 48'hfff0000, 32'h10000, -32'sd1);
    send_sample(-48'sh8000, -48'sh1, -48'sh10000, 32'h1, 32'shffff);
    send_sample(48'haaaa_aaaa_aaaa, 48'h5555_5555_5555, 48'haaaa_5555_aaaa,
                32'haaaa_aaaa, 32'sh5555_5555);
    drain();
  endtask

  task automatic test_origins();
    logic [CFG_W-1:0] vals [4] = '{24'h000000, 24'hffffff, 24'h7fffff, 24'h018000};
    for (int v = 0; v < 4; v++) begin
      write_reg(pns_pkg::REG_ORIGIN_X, vals[v]);
      write_reg(pns_pkg::REG_ORIGIN_Y, vals[(v + 1) % 4]);
      write_reg(pns_pkg::REG_ORIGIN_Z, vals[(v + 2) % 4]);
      run_bursts(40);
      drain();
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(pns_pkg::REG_ORIGIN_X, CFG_W'($urandom));
      write_reg(pns_pkg::REG_ORIGIN_Y, CFG_W'($urandom_range(0, 24'hffffff)));
      write_reg(pns_pkg::REG_ORIGIN_Z, CFG_W'($urandom));
      stall_level = ph % 3;
      run_bursts(120);
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    @(posedge clk);
    run_bursts(60);
    pause_input(1);
    while (noise_q.size() != 0) @(posedge clk);
    run_bursts(60);
    drain();
  endtask

  // receiver stall pattern, with a long hold-off when hold_req is set
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (cycles[7:6] == 2'd0) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_level)
        0:       out_stall <= ($urandom_range(7) == 0);
        1:       out_stall <= ($urandom_range(1) == 0);
        default: out_stall <= ($urandom_range(3) != 0);
      endcase
    end
  end

  // output transfer check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (noise_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected noise value %0d", noise_value);
      end else begin
        if (noise_value !== noise_q[0]) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("noise mismatch: expected %0d, got %0d", noise_q[0], noise_value);
        end
        void'(noise_q.pop_front());
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("perlin_noise_3d_sampler regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_origins();
    test_random();
    test_backpressure();
    if (noise_q.size() != 0) failed = 1'b1;
    $display("%0d table loads and %0d samples sent, %0d noise values checked, %0d mismatches",
             loads_sent, samples_sent, checked, mismatches);
    $display("origins swept through their extremes, idling and a long output hold-off applied");
    if (!failed)
      $display("perlin_noise_3d_sampler regression: pass");
    else
      $display("perlin_noise_3d_sampler regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
